### hdl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and index helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORD_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ACT_INS_FRONT = 2'd0,
		ACT_INS_REAR  = 2'd1,
		ACT_REM_FRONT = 2'd2,
		ACT_REM_REAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic exec;    // item accepted this cycle
		logic finish;  // read data of a removal is back
	} cdq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_read;  // accepted removal waits for store read
	} cdq_stat_t;

	function automatic idx_t wrap_up(input idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t wrap_down(input idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

endpackage

### hdl/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accepts items and holds off new ones while a removal reads.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cdq_stat_t stat,
	output cdq_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		cmd        = '0;
		state_n    = state_q;
		busy       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.exec = start;
				if (start && stat.need_read) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				cmd.finish = 1'b1;
				state_n    = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

### hdl/cdq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: head/tail indices, empty flag, entry store and result registers.
// ----------------------------------------------------------------------------
module cdq_dp import cdq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cdq_cmd_t    cmd,
	input  logic [1:0]  action,
	input  word_t       value,
	output cdq_stat_t   stat,
	output logic        done,
	output logic [1:0]  status,
	output word_t       removed_value,
	output logic        now_full,
	output logic        now_empty
);

	idx_t    head_q, tail_q, head_n, tail_n;
	logic    vacant_q, vacant_n;
	action_t action_q;
	logic    full_now;
	logic    fire;
	status_t st;
	word_t   rem;
	logic    we;
	idx_t    waddr, raddr;
	word_t   rdata;
	logic    done_q, full_q, empty_q;
	status_t status_q;
	word_t   removed_q;

	cdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign full_now = !vacant_q && (head_q == wrap_up(tail_q));

	always_comb begin
		head_n         = head_q;
		tail_n         = tail_q;
		vacant_n       = vacant_q;
		st             = ST_DONE;
		rem            = '0;
		we             = 1'b0;
		waddr          = head_q;
		raddr          = head_q;
		fire           = 1'b0;
		stat.need_read = 1'b0;
		if (cmd.exec) begin
			unique case (action_t'(action))
				ACT_INS_FRONT, ACT_INS_REAR: begin
					fire = 1'b1;
					if (full_now) begin
						st = ST_FULL;
					end else if (vacant_q) begin
						head_n   = '0;
						tail_n   = '0;
						vacant_n = 1'b0;
						we       = 1'b1;
						waddr    = '0;
					end else if (action_t'(action) == ACT_INS_FRONT) begin
						head_n = wrap_down(head_q);
						we     = 1'b1;
						waddr  = head_n;
					end else begin
						tail_n = wrap_up(tail_q);
						we     = 1'b1;
						waddr  = tail_n;
					end
				end
				ACT_REM_FRONT, ACT_REM_REAR: begin
					if (vacant_q) begin
						st   = ST_EMPTY;
						fire = 1'b1;
					end else begin
						raddr          = (action_t'(action) == ACT_REM_FRONT) ? head_q : tail_q;
						stat.need_read = 1'b1;
					end
				end
				default: begin
					fire = 1'b0;
				end
			endcase
		end else if (cmd.finish) begin
			fire = 1'b1;
			rem  = rdata;
			// last word out: return both indices to zero
			if (head_q == tail_q) begin
				head_n   = '0;
				tail_n   = '0;
				vacant_n = 1'b1;
			end else if (action_q == ACT_REM_FRONT) begin
				head_n = wrap_up(head_q);
			end else begin
				tail_n = wrap_down(tail_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			vacant_q <= 1'b1;
			done_q   <= 1'b0;
		end else begin
			head_q   <= head_n;
			tail_q   <= tail_n;
			vacant_q <= vacant_n;
			done_q   <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			action_q <= action_t'(action);
		end
		if (fire) begin
			status_q  <= st;
			removed_q <= rem;
			full_q    <= !vacant_n && (head_n == wrap_up(tail_n));
			empty_q   <= vacant_n;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign now_full      = full_q;
	assign now_empty     = empty_q;

endmodule

### hdl/circular_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of 32-bit words in a circular store of DEPTH entries.
// ----------------------------------------------------------------------------
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  command | start / busy     | action, value
//  result  | done (strobe)    | status, removed_value, now_full, now_empty
//
//  An item is taken at a rising edge with start high and busy low.
//  Inserts and refused operations strobe the result in the cycle after
//  acceptance and busy stays low, so a new item may follow at once.
//  A successful removal goes through the registered read port of the entry
//  store; busy is high in the read state while the read completes.
//  Reset (arst_n low) empties the deque; store contents are left as they are.
//  Results are shown for a single cycle; the receiver cannot stall them.
//
module circular_deque_unit import cdq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  word_t       value,
	output logic        done,
	output logic [1:0]  status,
	output word_t       removed_value,
	output logic        now_full,
	output logic        now_empty
);

	cdq_cmd_t  cmd;
	cdq_stat_t stat;

	// Sequence items: accept, and hold off new ones during a store read.
	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Move the indices, write and read the store, register the result.
	cdq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.value         (value),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.removed_value (removed_value),
		.now_full      (now_full),
		.now_empty     (now_empty)
	);

	// Busy drops again once a removal read has completed.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// A removal read always ends in a result.
	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("removal finished without a result");

	// Refusals carry no word.
	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_DONE)) |-> (removed_value == '0))
		else $error("refused item returned a word");

	// Refused removal means the deque is empty afterwards.
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (now_empty && !now_full))
		else $error("empty refusal with non-empty flags");

	// Full refusal leaves the deque full.
	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (now_full && !now_empty))
		else $error("full refusal with non-full flags");

endmodule
